// ----- rtl/cal_pkg.sv -----
// Shared types, constants and helper functions of the cache lookup block.
// No dependencies; every other file imports this package.
package cal_pkg;

  // Geometry and counter width
  localparam int SETS       = 64;
  localparam int WAYS       = 8;
  localparam int TAG_BITS   = 28;
  localparam int COUNT_BITS = 32;

  // Fixed field widths of the channels
  localparam int TAG_W = 28;
  localparam int SET_W = 6;
  localparam int WAY_W = 3;
  localparam int OUT_W = 32;

  localparam int SET_BITS   = $clog2(SETS);
  localparam int WAY_BITS   = $clog2(WAYS);
  localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'h0001;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    OC_HIT        = 2'd0,
    OC_PEND_HIT   = 2'd1,
    OC_READ_MISS  = 2'd2,
    OC_WRITE_MISS = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    FR_CLEAR,
    FR_IDLE,
    FR_LOOK,
    FR_WAIT
  } front_state_t;

  typedef struct packed {
    logic             mode;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_idx;
  } cal_access_t;

  typedef struct packed {
    outcome_t         outcome;
    logic [WAY_W-1:0] way;
    logic             memory_fetch;
    logic             memory_write;
    logic [OUT_W-1:0] hit_total;
    logic [OUT_W-1:0] miss_total;
    logic [OUT_W-1:0] pending_total;
    logic [OUT_W-1:0] through_total;
    logic [OUT_W-1:0] noalloc_total;
  } cal_result_t;

  // Classified access travelling from front to back, with the set's line state
  typedef struct packed {
    logic                  is_write;
    logic [STORE_BITS-1:0] tag;
    logic [SET_BITS-1:0]   set;
    logic                  hit;
    logic                  pending;
    logic [WAY_BITS-1:0]   way;
    logic [WAYS-1:0]       vrow;
    logic [WAYS-1:0]       prow;
  } cal_job_t;

  // Completion, new line state and tag write, back to front
  typedef struct packed {
    logic                  done;
    logic                  wr_en;
    logic [SET_BITS-1:0]   row;
    logic [WAY_BITS-1:0]   way;
    logic [STORE_BITS-1:0] tag;
    logic [WAYS-1:0]       valid;
    logic [WAYS-1:0]       pending;
  } back_note_t;

  // Set index wraps modulo SETS: constant table over all index codes
  typedef logic [SET_BITS-1:0] set_map_t [2**SET_W];

  function automatic set_map_t build_set_map();
    set_map_t m;
    int       cnt;
    cnt = 0;
    for (int i = 0; i < 2**SET_W; i++) begin
      m[i] = SET_BITS'(cnt);
      cnt++;
      if (cnt == SETS) cnt = 0;
    end
    return m;
  endfunction

  localparam set_map_t SET_MAP = build_set_map();

  // Victim modulo WAYS: per-bit weights 2^k mod WAYS, then a fold table
  typedef logic [7:0] pow_mod_t [LFSR_W];
  typedef logic [WAY_BITS-1:0] fold_mod_t [256];

  function automatic pow_mod_t build_pow_mod();
    pow_mod_t m;
    int       p;
    p = 1 % WAYS;
    for (int k = 0; k < LFSR_W; k++) begin
      m[k] = 8'(p);
      p = p * 2;
      if (p >= WAYS) p = p - WAYS;
    end
    return m;
  endfunction

  function automatic fold_mod_t build_fold_mod();
    fold_mod_t m;
    int        cnt;
    cnt = 0;
    for (int i = 0; i < 256; i++) begin
      m[i] = WAY_BITS'(cnt);
      cnt++;
      if (cnt == WAYS) cnt = 0;
    end
    return m;
  endfunction

  localparam pow_mod_t  POW_MOD  = build_pow_mod();
  localparam fold_mod_t FOLD_MOD = build_fold_mod();

  function automatic logic [WAY_BITS-1:0] lfsr_victim(input logic [LFSR_W-1:0] x);
    logic [7:0] sum;
    sum = '0;
    if ((WAYS & (WAYS - 1)) == 0) return x[WAY_BITS-1:0];
    for (int k = 0; k < LFSR_W; k++) begin
      if (x[k]) sum = sum + POW_MOD[k];
    end
    return FOLD_MOD[sum];
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] x);
    return x[0] ? ((x >> 1) ^ LFSR_MASK) : (x >> 1);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] count_field(input logic [COUNT_BITS-1:0] c);
    logic [OUT_W-1:0] r;
    r = '0;
    for (int i = 0; i < OUT_W; i++) begin
      if (i < COUNT_BITS) r[i] = c[i];
    end
    return r;
  endfunction

  function automatic logic [WAY_W-1:0] way_field(input logic [WAY_BITS-1:0] w);
    logic [WAY_W-1:0] r;
    r = '0;
    for (int i = 0; i < WAY_W; i++) begin
      if (i < WAY_BITS) r[i] = w[i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/cal_access_if.sv -----
// Access channel: valid/ready handshake carrying one cache access per beat.
// Depends on cal_pkg.
interface cal_access_if import cal_pkg::*; ();
  logic        valid;
  logic        ready;
  cal_access_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/cal_result_if.sv -----
// Result channel: valid/ready handshake carrying one lookup result per beat.
// Depends on cal_pkg.
interface cal_result_if import cal_pkg::*; ();
  logic        valid;
  logic        ready;
  cal_result_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/cal_front.sv -----
// Front end: accepts an access, reads the tag and line-state rows and classifies hit/miss.
// Depends on cal_pkg and cal_access_if; owns the tag store and line-state memories.
module cal_front import cal_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cal_access_if.sink req,
  output cal_job_t   job,
  output logic       job_valid,
  input  logic       job_ready,
  input  back_note_t note
);

  front_state_t state, state_next;

  logic [WAYS-1:0][STORE_BITS-1:0] tag_mem [SETS];
  logic [WAYS-1:0]                 line_valid   [SETS];
  logic [WAYS-1:0]                 line_pending [SETS];
  logic [WAYS-1:0][STORE_BITS-1:0] tag_row;
  logic [WAYS-1:0]                 vrow;
  logic [WAYS-1:0]                 prow;
  logic [SET_BITS-1:0]             clr_set;

  logic                  is_write;
  logic [STORE_BITS-1:0] tag;
  logic [SET_BITS-1:0]   set;

  logic                accept;
  logic [SET_BITS-1:0] acc_set;
  logic [WAYS-1:0]     settled;
  logic [WAYS-1:0]     pend_match;
  logic                found;
  logic                found_pend;
  logic [WAY_BITS-1:0] found_way;

  assign accept  = req.valid && req.ready;
  assign acc_set = SET_MAP[req.data.set_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Walk every set once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_set <= '0;
    end else if (state == FR_CLEAR) begin
      clr_set <= clr_set + 1'b1;
    end
  end

  // Capture the access and read its tag and line-state rows on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      is_write <= (req.data.mode == MODE_WRITE);
      tag      <= req.data.tag[STORE_BITS-1:0];
      set      <= acc_set;
      tag_row  <= tag_mem[acc_set];
      vrow     <= line_valid[acc_set];
      prow     <= line_pending[acc_set];
    end
  end

  always_ff @(posedge clk) begin
    if (note.wr_en) begin
      tag_mem[note.row][note.way] <= note.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_CLEAR) begin
      line_valid[clr_set]   <= '0;
      line_pending[clr_set] <= '0;
    end else if (note.done) begin
      line_valid[note.row]   <= note.valid;
      line_pending[note.row] <= note.pending;
    end
  end

  // Lowest way that is a settled hit or a pending match wins
  always_comb begin
    found      = 1'b0;
    found_pend = 1'b0;
    found_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      settled[w]    = (tag_row[w] == tag) && vrow[w] && !prow[w];
      pend_match[w] = (tag_row[w] == tag) && prow[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (settled[w] || pend_match[w]) begin
        found      = 1'b1;
        found_pend = pend_match[w];
        found_way  = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    job.is_write = is_write;
    job.tag      = tag;
    job.set      = set;
    job.hit      = found;
    job.pending  = found_pend;
    job.way      = found_way;
    job.vrow     = vrow;
    job.prow     = prow;
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    job_valid  = 1'b0;
    case (state)
      FR_CLEAR: begin
        if (clr_set == SET_BITS'(SETS - 1)) state_next = FR_IDLE;
      end
      FR_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = FR_LOOK;
      end
      FR_LOOK: begin
        job_valid = 1'b1;
        if (job_ready) state_next = FR_WAIT;
      end
      FR_WAIT: begin
        if (note.done) state_next = FR_IDLE;
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/cal_queue.sv -----
// Short queue of classified accesses between front and back.
// Depends on cal_pkg.
module cal_queue import cal_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cal_job_t push_job,
  input  logic     push_valid,
  output logic     push_ready,
  output cal_job_t pop_job,
  output logic     pop_valid,
  input  logic     pop_ready
);

  cal_job_t entries [QUEUE_DEPTH];

  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/cal_back.sv -----
// Back end: works out the new line state, victim LFSR and counters for a
// classified access and holds the result register. Depends on cal_pkg, cal_result_if.
module cal_back import cal_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cal_job_t     job,
  input  logic         job_valid,
  output logic         job_ready,
  output back_note_t   note,
  cal_result_if.source rsp
);

  logic [LFSR_W-1:0]     victim_lfsr;
  logic [COUNT_BITS-1:0] hit_count, miss_count, pending_count, through_count, noalloc_count;
  logic [COUNT_BITS-1:0] hit_next, miss_next, pending_next, through_next, noalloc_next;
  logic                  out_valid;
  cal_result_t           rsp_data;
  cal_result_t           result;

  logic                pop;
  logic [WAYS-1:0]     vrow, prow, vrow_next, prow_next;
  logic                free;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] victim;
  logic                alloc;
  logic                use_lfsr;

  assign job_ready = !out_valid || rsp.ready;
  assign pop       = job_valid && job_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = rsp_data;

  assign vrow     = job.vrow;
  assign prow     = job.prow;
  assign alloc    = !job.hit && !job.is_write;
  assign use_lfsr = alloc && !free;
  assign victim   = free ? free_way : lfsr_victim(victim_lfsr);

  assign note.done    = pop;
  assign note.wr_en   = pop && alloc;
  assign note.row     = job.set;
  assign note.way     = victim;
  assign note.tag     = job.tag;
  assign note.valid   = vrow_next;
  assign note.pending = prow_next;

  // First invalid way of the set
  always_comb begin
    free     = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow[w]) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    vrow_next    = vrow;
    prow_next    = prow;
    hit_next     = hit_count;
    miss_next    = miss_count;
    pending_next = pending_count;
    through_next = through_count;
    noalloc_next = noalloc_count;

    result.outcome      = OC_HIT;
    result.way          = way_field(job.way);
    result.memory_fetch = 1'b0;
    result.memory_write = 1'b0;

    if (job.hit && !job.pending) begin
      hit_next = sat_inc(hit_count);
      if (job.is_write) begin
        result.memory_write = 1'b1;
        through_next        = sat_inc(through_count);
      end
    end else if (job.hit) begin
      result.outcome       = OC_PEND_HIT;
      hit_next             = sat_inc(hit_count);
      pending_next         = sat_inc(pending_count);
      prow_next[job.way]   = 1'b0;
      vrow_next[job.way]   = 1'b1;
    end else if (job.is_write) begin
      result.outcome      = OC_WRITE_MISS;
      result.way          = '0;
      result.memory_write = 1'b1;
      miss_next           = sat_inc(miss_count);
      noalloc_next        = sat_inc(noalloc_count);
    end else begin
      result.outcome      = OC_READ_MISS;
      result.way          = way_field(victim);
      result.memory_fetch = 1'b1;
      miss_next           = sat_inc(miss_count);
      vrow_next[victim]   = 1'b1;
      prow_next[victim]   = 1'b1;
    end

    result.hit_total     = count_field(hit_next);
    result.miss_total    = count_field(miss_next);
    result.pending_total = count_field(pending_next);
    result.through_total = count_field(through_next);
    result.noalloc_total = count_field(noalloc_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      victim_lfsr   <= LFSR_SEED;
      hit_count     <= '0;
      miss_count    <= '0;
      pending_count <= '0;
      through_count <= '0;
      noalloc_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        hit_count     <= hit_next;
        miss_count    <= miss_next;
        pending_count <= pending_next;
        through_count <= through_next;
        noalloc_count <= noalloc_next;
        if (use_lfsr) victim_lfsr <= lfsr_step(victim_lfsr);
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_data <= result;
    end
  end

endmodule

// ----- rtl/set_assoc_cache_lookup_unit.sv -----
// Top level of the set-associative cache lookup (write-through, no allocate).
// Depends on cal_pkg, cal_access_if, cal_result_if, cal_front, cal_queue, cal_back.
//
//   channel | modport | beat carries                 | accepted when
//   --------+---------+------------------------------+---------------------
//   req     | sink    | mode, tag, set_idx           | req.valid & req.ready
//   rsp     | source  | outcome, way, memory flags,  | rsp.valid & rsp.ready
//           |         | five saturating totals       |
//
// The tag and line-state rows are read on the accepting edge; the access is
// then classified in FR_LOOK and pushed into the queue, and the back end pops
// it, applies it and loads the result register, which drives rsp.valid. The
// front end holds one access at a time and takes the next only once the back
// end has applied the last one, so a new access waits for the previous one.
// A stalled rsp holds the result register and, behind it, the queue and the
// front end. Reset (rst, synchronous) clears counters and the LFSR at once; the
// front end then walks all 64 sets clearing valid/pending bits, holding
// req.ready low until the walk is done. The tag store needs no clearing since
// tags are compared only on lines marked valid or pending.
module set_assoc_cache_lookup_unit import cal_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  cal_access_if.sink   req,
  cal_result_if.source rsp
);

  cal_job_t   front_job;
  logic       front_valid;
  logic       front_ready;
  cal_job_t   back_job;
  logic       back_valid;
  logic       back_ready;
  back_note_t note;

  // Accept and classify; tag store and line state live here
  cal_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .note      (note)
  );

  // Decouple classification from state update
  cal_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // Work out line state, victim choice and counters; drive rsp
  cal_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .note      (note),
    .rsp       (rsp)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for set_assoc_cache_lookup_unit: directed and random accesses
// with random idling on both channels, checked against an in-bench tag-store predictor.
// Depends on cal_pkg, cal_access_if, cal_result_if and the RTL of the lookup unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cal_pkg::*;

  localparam int RANDOM_BEATS = 600;
  localparam int POOL_TAGS    = 12;
  localparam int HOT_SETS     = 4;
  localparam int STALL_LIMIT  = 5000;  // cycles without any beat before giving up
  localparam int TAIL_CYCLES  = 20;    // quiet time after the last result

  logic clk = 1'b0;
  logic rst;

  always #1 clk = ~clk;

  cal_access_if acc_ch ();
  cal_result_if res_ch ();

  set_assoc_cache_lookup_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (acc_ch),
    .rsp (res_ch)
  );

  // ---------------------------------------------------------------------------
  // Tag-store predictor: own copy of line state, victim LFSR and statistics
  // ---------------------------------------------------------------------------
  logic [WAYS-1:0]       way_valid   [SETS];
  logic [WAYS-1:0]       way_pending [SETS];
  logic [STORE_BITS-1:0] way_tag     [SETS][WAYS];
  logic [LFSR_W-1:0]     victim_seed;
  logic [COUNT_BITS-1:0] hits, misses, pend_hits, write_throughs, write_misses;
  int                    lfsr_evictions;
  int                    read_fills;

  function automatic void reset_model();
    for (int s = 0; s < SETS; s++) begin
      way_valid[s]   = '0;
      way_pending[s] = '0;
      for (int w = 0; w < WAYS; w++) way_tag[s][w] = '0;
    end
    victim_seed    = LFSR_SEED;
    hits           = '0;
    misses         = '0;
    pend_hits      = '0;
    write_throughs = '0;
    write_misses   = '0;
    lfsr_evictions = 0;
    read_fills     = 0;
  endfunction

  // Counters stick at all-ones instead of wrapping
  function automatic void bump_count(ref logic [COUNT_BITS-1:0] c);
    if (c != '1) c = c + 1'b1;
  endfunction

  // Classify one access against the set, update line state and counters,
  // and return the result the block must produce for it.
  function automatic cal_result_t classify_access(input cal_access_t a);
    cal_result_t r;
    int          s;
    int          found;
    int          victim;
    r      = '0;
    s      = int'(a.set_idx) % SETS;
    found  = -1;
    victim = -1;
    // Lowest way holding the tag, settled or still pending, decides
    for (int w = 0; w < WAYS; w++) begin
      if (found < 0 && (way_valid[s][w] || way_pending[s][w]) &&
          way_tag[s][w] == a.tag[STORE_BITS-1:0])
        found = w;
    end
    if (found >= 0) begin
      r.way = WAY_W'(found);
      bump_count(hits);
      if (way_pending[s][found]) begin
        // Line still being fetched: settle it, never write through
        r.outcome = OC_PEND_HIT;
        bump_count(pend_hits);
        way_pending[s][found] = 1'b0;
        way_valid[s][found]   = 1'b1;
      end else begin
        r.outcome = OC_HIT;
        if (a.mode == MODE_WRITE) begin
          r.memory_write = 1'b1;
          bump_count(write_throughs);
        end
      end
    end else begin
      bump_count(misses);
      if (a.mode == MODE_WRITE) begin
        // No allocate: the write goes to memory only
        r.outcome      = OC_WRITE_MISS;
        r.memory_write = 1'b1;
        bump_count(write_misses);
      end else begin
        for (int w = 0; w < WAYS; w++) begin
          if (victim < 0 && !way_valid[s][w]) victim = w;
        end
        if (victim < 0) begin
          // Set full: take the LFSR's pick, then shift it once (Galois, right)
          victim      = int'(victim_seed % WAYS);
          victim_seed = victim_seed[0] ? ((victim_seed >> 1) ^ LFSR_MASK)
                                       : (victim_seed >> 1);
          lfsr_evictions++;
        end
        read_fills++;
        way_tag[s][victim]     = a.tag[STORE_BITS-1:0];
        way_valid[s][victim]   = 1'b1;
        way_pending[s][victim] = 1'b1;
        r.outcome      = OC_READ_MISS;
        r.way          = WAY_W'(victim);
        r.memory_fetch = 1'b1;
      end
    end
    r.hit_total     = OUT_W'(hits);
    r.miss_total    = OUT_W'(misses);
    r.pending_total = OUT_W'(pend_hits);
    r.through_total = OUT_W'(write_throughs);
    r.noalloc_total = OUT_W'(write_misses);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  typedef struct {
    cal_access_t acc;
    int          gap;    // idle cycles before this beat is offered
    bit          drain;  // hold the beat until every outstanding result is back
  } access_plan_t;

  access_plan_t access_plan      [$];
  cal_result_t  lookup_outcomes  [$];
  int           accesses_sent = 0;
  int           results_seen  = 0;
  int           mismatches    = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
             $time, results_seen, what, got, want);
  endtask

  // Mostly short pauses, now and then a long one
  function automatic int pick_idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void plan_access(input logic mode, input logic [TAG_W-1:0] tag,
                                      input logic [SET_W-1:0] set_idx,
                                      input bit drain, input int gap);
    access_plan_t p;
    p.acc.mode    = mode;
    p.acc.tag     = tag;
    p.acc.set_idx = set_idx;
    p.drain       = drain;
    p.gap         = gap;
    access_plan.push_back(p);
  endfunction

  // ---------------------------------------------------------------------------
  // Access driver: offer planned beats, predict each one as it is accepted
  // ---------------------------------------------------------------------------
  int hold_cycles = 0;
  bit gap_done    = 1'b0;

  always @(posedge clk) begin : drive_access
    int n_sent;
    n_sent = accesses_sent;
    if (rst) begin
      acc_ch.valid <= 1'b0;
      acc_ch.data  <= '0;
      hold_cycles  <= 0;
      gap_done     <= 1'b0;
      reset_model();
    end else begin
      if (acc_ch.valid && acc_ch.ready) begin
        lookup_outcomes.push_back(classify_access(acc_ch.data));
        n_sent++;
      end
      if (acc_ch.valid && !acc_ch.ready) begin
        // hold the beat until the block takes it
      end else if (hold_cycles > 0) begin
        acc_ch.valid <= 1'b0;
        hold_cycles  <= hold_cycles - 1;
      end else if (access_plan.size() == 0) begin
        acc_ch.valid <= 1'b0;
      end else if (access_plan[0].drain && results_seen != n_sent) begin
        // pause here until the pipe has emptied completely
        acc_ch.valid <= 1'b0;
      end else if (!gap_done && access_plan[0].gap > 0) begin
        acc_ch.valid <= 1'b0;
        hold_cycles  <= access_plan[0].gap - 1;
        gap_done     <= 1'b1;
      end else begin
        acc_ch.valid <= 1'b1;
        acc_ch.data  <= access_plan[0].acc;
        gap_done     <= 1'b0;
        access_plan.pop_front();
      end
      accesses_sent <= n_sent;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each beat with the oldest prediction, stall at random
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : watch_results
    cal_result_t want;
    cal_result_t got;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (lookup_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(got.outcome), '0);
        end else begin
          want = lookup_outcomes.pop_front();
          if (got.outcome !== want.outcome)
            report_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
          if (got.way !== want.way)
            report_mismatch("way", 32'(got.way), 32'(want.way));
          if (got.memory_fetch !== want.memory_fetch)
            report_mismatch("memory_fetch", 32'(got.memory_fetch), 32'(want.memory_fetch));
          if (got.memory_write !== want.memory_write)
            report_mismatch("memory_write", 32'(got.memory_write), 32'(want.memory_write));
          if (got.hit_total !== want.hit_total)
            report_mismatch("hit_total", got.hit_total, want.hit_total);
          if (got.miss_total !== want.miss_total)
            report_mismatch("miss_total", got.miss_total, want.miss_total);
          if (got.pending_total !== want.pending_total)
            report_mismatch("pending_total", got.pending_total, want.pending_total);
          if (got.through_total !== want.through_total)
            report_mismatch("through_total", got.through_total, want.through_total);
          if (got.noalloc_total !== want.noalloc_total)
            report_mismatch("noalloc_total", got.noalloc_total, want.noalloc_total);
        end
        results_seen <= results_seen + 1;
      end
      // Every third stretch of 64 results runs with ready held high
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (((results_seen / 64) % 3) == 2) begin
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b0;
        stall_left   <= pick_idle_span();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on either channel for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (acc_ch.valid && acc_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat on either channel for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_plan
    logic [TAG_W-1:0] tag_pool [POOL_TAGS];
    logic [SET_W-1:0] hot_sets [HOT_SETS];
    logic             mode;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_idx;
    bit               calm;

    rst = 1'b1;

    // Directed: one line through its life, field extremes, a set filled and
    // then overflowed so that victims come from the LFSR.
    plan_access(MODE_READ,  '0, '0, 1'b0, 0);  // read miss, fills way 0
    plan_access(MODE_READ,  '0, '0, 1'b0, 0);  // hit on a pending line
    plan_access(MODE_READ,  '0, '0, 1'b0, 1);  // settled hit
    plan_access(MODE_WRITE, '0, '0, 1'b0, 0);  // write hit, goes through
    plan_access(MODE_WRITE, '1, '1, 1'b0, 0);  // write miss, no allocate
    plan_access(MODE_READ,  '1, '1, 1'b0, 2);  // read miss in the top set
    plan_access(MODE_WRITE, '1, '1, 1'b0, 0);  // write to pending line: no memory write
    plan_access(MODE_WRITE, '1, '1, 1'b0, 0);  // now settled: write through
    for (int t = 1; t < WAYS; t++)
      plan_access(MODE_READ, TAG_W'(t), '0, 1'b0, t % 2);  // fill the rest of set 0
    plan_access(MODE_READ,  TAG_W'(WAYS),     '0, 1'b0, 0);  // set full: LFSR victim
    plan_access(MODE_READ,  TAG_W'(WAYS + 1), '0, 1'b0, 0);
    plan_access(MODE_READ,  TAG_W'(1),        '0, 1'b0, 0);  // evicted tag misses again
    plan_access(MODE_WRITE, 28'hAAA_AAAA, 6'd42, 1'b0, 0);
    plan_access(MODE_READ,  28'h555_5555, 6'd21, 1'b0, 0);

    // Random: most beats reuse a small pool of tags on a few sets so lines are
    // filled, hit while pending, settled and evicted; the rest are noise.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int k = 2; k < POOL_TAGS; k++) tag_pool[k] = TAG_W'($urandom);
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int k = 2; k < HOT_SETS; k++) hot_sets[k] = SET_W'($urandom);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm = ((i / 50) % 3) == 1;
      mode = ($urandom_range(0, 99) < 60) ? MODE_READ : MODE_WRITE;
      if ($urandom_range(0, 99) < 75) begin
        tag     = tag_pool[$urandom_range(0, POOL_TAGS - 1)];
        set_idx = hot_sets[$urandom_range(0, HOT_SETS - 1)];
      end else begin
        tag     = TAG_W'($urandom);
        set_idx = SET_W'($urandom);
      end
      plan_access(mode, tag, set_idx, i == 0 || i == RANDOM_BEATS / 2,
                  calm ? 0 : pick_idle_span());
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain: every beat offered, taken, and answered
    while (access_plan.size() != 0 || acc_ch.valid || results_seen != accesses_sent)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (lookup_outcomes.size() != 0)
      report_mismatch("predictions left without a result", 32'(lookup_outcomes.size()), '0);

    $display("Ran %0d accesses: %0d hits (%0d on pending lines), %0d write-throughs",
             accesses_sent, hits, pend_hits, write_throughs);
    $display("  %0d read fills (%0d chosen by the LFSR), %0d unallocated write misses",
             read_fills, lfsr_evictions, write_misses);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
